/* sv/svc_pkg.sv */
// Shared types, register indexes and constants of the speed volume controller.
`timescale 1ns / 1ps
package svc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_BOOST_ENABLE   = 3'd0;
    localparam cfg_idx_t REG_HIGH_SPEED_MPH = 3'd1;
    localparam cfg_idx_t REG_BOOST_STEP     = 3'd2;
    localparam cfg_idx_t REG_QUIET_ENABLE   = 3'd3;
    localparam cfg_idx_t REG_LOW_SPEED_MPH  = 3'd4;
    localparam cfg_idx_t REG_QUIET_LEVEL    = 3'd5;
    localparam cfg_idx_t REG_CHECK_INTERVAL = 3'd6;

    localparam logic [7:0]  RST_HIGH_SPEED_MPH = 8'd45;
    localparam logic [3:0]  RST_BOOST_STEP     = 4'd1;
    localparam logic [7:0]  RST_LOW_SPEED_MPH  = 8'd5;
    localparam logic [3:0]  RST_QUIET_LEVEL    = 4'd0;
    localparam logic [15:0] RST_CHECK_INTERVAL = 16'd500;

    // Highest volume a boost may reach.
    localparam logic [3:0] BOOST_CEILING = 4'd9;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_BOOST   = 2'd1,
        ACT_QUIET   = 2'd2,
        ACT_RESTORE = 2'd3
    } act_t;

    typedef struct packed {
        logic        boost_enable;
        logic [7:0]  high_speed_mph;
        logic [3:0]  boost_step;
        logic        quiet_enable;
        logic [7:0]  low_speed_mph;
        logic [3:0]  quiet_level;
        logic [15:0] eval_period_ms;
    } cfg_t;

    typedef struct packed {
        logic        link_up;
        logic        fade_owns;
        logic        proxy_active;
        logic [3:0]  volume_now;
        logic [3:0]  mute_now;
        logic [11:0] speed_q4;
        logic        speed_ok;
        logic [31:0] time_ms;
    } tick_t;

    typedef struct packed {
        act_t       action;
        logic [3:0] set_volume;
        logic [3:0] set_mute;
    } result_t;

    typedef struct packed {
        logic        boosting;
        logic        quieting;
        logic [3:0]  saved_boost_volume;
        logic [3:0]  saved_quiet_volume;
        logic [31:0] last_check_time;
    } state_t;

endpackage

/* sv/svc_if.sv */
// Request channels of the speed volume controller: evaluation ticks in, actions out.
`timescale 1ns / 1ps
interface svc_tick_if;
    logic        valid;
    logic        ready;
    logic        link_up;
    logic        fade_owns;
    logic        proxy_active;
    logic [3:0]  volume_now;
    logic [3:0]  mute_now;
    logic [11:0] speed_q4;
    logic        speed_ok;
    logic [31:0] time_ms;

    modport source (
        output valid, link_up, fade_owns, proxy_active, volume_now, mute_now,
               speed_q4, speed_ok, time_ms,
        input  ready
    );
    modport sink (
        input  valid, link_up, fade_owns, proxy_active, volume_now, mute_now,
               speed_q4, speed_ok, time_ms,
        output ready
    );
endinterface

interface svc_act_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] set_volume;
    logic [3:0] set_mute;

    modport source (
        output valid, action, set_volume, set_mute,
        input  ready
    );
    modport sink (
        input  valid, action, set_volume, set_mute,
        output ready
    );
endinterface

/* sv/svc_cfg_regs.sv */
// Configuration register file of the speed volume controller.
`timescale 1ns / 1ps
module svc_cfg_regs
    import svc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  cfg_idx_t              cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boost_enable   <= 1'b0;
            cfg_reg.high_speed_mph <= RST_HIGH_SPEED_MPH;
            cfg_reg.boost_step     <= RST_BOOST_STEP;
            cfg_reg.quiet_enable   <= 1'b0;
            cfg_reg.low_speed_mph  <= RST_LOW_SPEED_MPH;
            cfg_reg.quiet_level    <= RST_QUIET_LEVEL;
            cfg_reg.eval_period_ms <= RST_CHECK_INTERVAL;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx)
                REG_BOOST_ENABLE:   cfg_reg.boost_enable   <= cfg_data[0];
                REG_HIGH_SPEED_MPH: cfg_reg.high_speed_mph <= cfg_data[7:0];
                REG_BOOST_STEP:     cfg_reg.boost_step     <= cfg_data[3:0];
                REG_QUIET_ENABLE:   cfg_reg.quiet_enable   <= cfg_data[0];
                REG_LOW_SPEED_MPH:  cfg_reg.low_speed_mph  <= cfg_data[7:0];
                REG_QUIET_LEVEL:    cfg_reg.quiet_level    <= cfg_data[3:0];
                REG_CHECK_INTERVAL: cfg_reg.eval_period_ms <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/svc_eval.sv */
// Decision logic for one evaluation tick: the action to give and the next controller state.
`timescale 1ns / 1ps
module svc_eval
    import svc_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  state,
    input  tick_t   tick,
    output result_t result,
    output state_t  state_next
);

    logic [31:0] elapsed;
    logic        want_quiet;
    logic        want_boost;
    logic [4:0]  boost_sum;
    logic [3:0]  boost_target;

    assign elapsed    = tick.time_ms - state.last_check_time;
    assign want_quiet = cfg.quiet_enable && tick.speed_ok &&
                        (tick.speed_q4 < {cfg.low_speed_mph, 4'b0000});
    assign want_boost = tick.speed_q4 >= {cfg.high_speed_mph, 4'b0000};
    assign boost_sum  = {1'b0, tick.volume_now} + {1'b0, cfg.boost_step};
    assign boost_target = (boost_sum > {1'b0, BOOST_CEILING}) ? BOOST_CEILING
                                                              : boost_sum[3:0];

    always_comb
    begin
        result.action     = ACT_NONE;
        result.set_volume = 4'd0;
        result.set_mute   = tick.mute_now;
        state_next        = state;

        if (tick.proxy_active || !cfg.boost_enable || !tick.link_up || tick.fade_owns)
        begin
            // A fade owner keeps control of the volume, unless a proxy is attached too.
            if (tick.proxy_active || !tick.fade_owns)
            begin
                if (state.boosting && tick.volume_now != state.saved_boost_volume)
                begin
                    result.action     = ACT_RESTORE;
                    result.set_volume = state.saved_boost_volume;
                end
                // The quiet restore takes precedence over the boost restore.
                if (state.quieting && tick.volume_now != state.saved_quiet_volume)
                begin
                    result.action     = ACT_RESTORE;
                    result.set_volume = state.saved_quiet_volume;
                end
            end
            state_next = '0;
        end
        else if (elapsed >= {16'd0, cfg.eval_period_ms})
        begin
            state_next.last_check_time = tick.time_ms;
            priority if (want_quiet && !state.quieting)
            begin
                state_next.saved_quiet_volume = tick.volume_now;
                state_next.quieting           = 1'b1;
                if (tick.volume_now != cfg.quiet_level)
                begin
                    result.action     = ACT_QUIET;
                    result.set_volume = cfg.quiet_level;
                end
            end
            else if (!want_quiet && state.quieting)
            begin
                if (tick.volume_now != state.saved_quiet_volume)
                begin
                    result.action     = ACT_RESTORE;
                    result.set_volume = state.saved_quiet_volume;
                end
                state_next.quieting           = 1'b0;
                state_next.saved_quiet_volume = 4'd0;
            end
            else if (want_boost && !state.boosting)
            begin
                // No boost starts when the ceiling leaves no headroom.
                if (boost_target > tick.volume_now)
                begin
                    state_next.saved_boost_volume = tick.volume_now;
                    state_next.boosting           = 1'b1;
                    result.action                 = ACT_BOOST;
                    result.set_volume             = boost_target;
                end
            end
            else if (!want_boost && state.boosting)
            begin
                if (tick.volume_now != state.saved_boost_volume)
                begin
                    result.action     = ACT_RESTORE;
                    result.set_volume = state.saved_boost_volume;
                end
                // Ending a boost drops everything, the check time included.
                state_next = '0;
            end
            else
            begin
                // The speed condition is unchanged; only the check time moves.
            end
        end
    end

endmodule

/* sv/speed_volume_controller.sv */
// Top level of the speed volume controller: tick register, decision logic, action register.
`timescale 1ns / 1ps
// Usage
// The block raises the main volume at high speed and lowers it at low speed, and
// restores the saved volume once the condition ends or the feature loses control.
// Each evaluation tick arrives as a request on the tick channel (valid/ready) and
// produces exactly one request on the result channel: an action code, a volume to
// apply and the mute volume passed through from the tick.
// Configuration is a plain write port (cfg_wen, cfg_idx, cfg_data) and must only
// be written while no tick is in flight; indexes beyond the register list are ignored.
// Path: a taken tick is held in the tick register, evaluated from there by the decision
// logic and presented from the action register.
// Throughput: one tick per cycle while the receiver keeps up. The controller state
// (flags, saved volumes, last check time) is updated in the same cycle that writes the
// action register, so the next tick always sees the state left by the one before it.
// When the receiver stalls, the action register holds its request and the tick
// register can still take one more tick; ready drops only when both are full.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the state
// and returns every configuration register to its default.
module speed_volume_controller
    import svc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    svc_tick_if.sink              tick,
    svc_act_if.source             result,
    input  logic                  cfg_wen,
    input  cfg_idx_t              cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    take;

    svc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    svc_eval u_eval (
        .cfg        (cfg),
        .state      (state_reg),
        .tick       (tick_reg),
        .result     (res_next),
        .state_next (state_next)
    );

    // The action register can load whenever it is empty or being drained.
    assign advance    = !res_valid_reg || result.ready;
    assign take       = tick_valid_reg && advance;
    assign tick.ready = !tick_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (tick.ready)
            begin
                tick_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                res_valid_reg <= tick_valid_reg;
            end
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            tick_reg.link_up      <= tick.link_up;
            tick_reg.fade_owns    <= tick.fade_owns;
            tick_reg.proxy_active <= tick.proxy_active;
            tick_reg.volume_now   <= tick.volume_now;
            tick_reg.mute_now     <= tick.mute_now;
            tick_reg.speed_q4     <= tick.speed_q4;
            tick_reg.speed_ok     <= tick.speed_ok;
            tick_reg.time_ms      <= tick.time_ms;
        end
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.action     = res_reg.action;
    assign result.set_volume = res_reg.set_volume;
    assign result.set_mute   = res_reg.set_mute;

    // A saved boost volume always had headroom below the ceiling.
    a_boost_saved_below_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.boosting |-> state_reg.saved_boost_volume < BOOST_CEILING)
        else $error("saved boost volume at or above the ceiling");

    // Saved volumes are cleared whenever their flag is down.
    a_saved_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (!state_reg.boosting |-> state_reg.saved_boost_volume == 4'd0) and
        (!state_reg.quieting |-> state_reg.saved_quiet_volume == 4'd0))
        else $error("saved volume kept without its flag");

    // The controller state moves only when a tick is evaluated.
    a_state_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(state_reg))
        else $error("controller state changed without a tick");

    // A boost request carries a volume between one and the ceiling.
    a_boost_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.action == ACT_BOOST) |->
        (res_reg.set_volume != 4'd0 && res_reg.set_volume <= BOOST_CEILING))
        else $error("boost volume out of range");

    // A request without an action carries volume zero.
    a_none_zero_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.action == ACT_NONE) |-> res_reg.set_volume == 4'd0)
        else $error("nonzero volume with no action");

endmodule
